[hdl/tst_pkg.sv]
`default_nettype none

package tst_pkg;

   // slot count default and the cap on fired items per tick
   localparam int DEFAULT_SLOTS = 16;
   localparam int MAX_FIRED     = 16;
   localparam int FIRE_CNT_W    = $clog2(MAX_FIRED + 1);

   // command codes (req_tuser)
   localparam logic [1:0] CMD_ATTACH_ONCE = 2'd0;
   localparam logic [1:0] CMD_ATTACH_PER  = 2'd1;
   localparam logic [1:0] CMD_DETACH      = 2'd2;
   localparam logic [1:0] CMD_TICK        = 2'd3;

   // result kinds (rsp_tuser)
   localparam logic [1:0] KIND_ATTACHED = 2'd0;
   localparam logic [1:0] KIND_FULL     = 2'd1;
   localparam logic [1:0] KIND_FIRED    = 2'd2;

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_ATTACH = 4'b0010,
      S_TICK   = 4'b0100,
      S_FLUSH  = 4'b1000
   } state_type;

endpackage

`default_nettype wire

[hdl/timer_slot_table.sv]
`default_nettype none

// channel   dir  payload                                            handshake
// req_      in   tuser: cmd[1:0]                                    tvalid/tready
//                tdata: now[31:0] interval[63:32] slot[67:64]
// rsp_      out  tuser: kind[1:0]  tdata: slot_res[3:0]  tlast: last tvalid/tready
//
// attach scans from slot 0 to the first free slot; tick reads one slot per cycle
// through the timing memory while the tick scan is not stalled
// reset: synchronous, active high; slot flags clear at once, no memory clear pass
// stalls: a full result register holds the attach scan, the tick scan stops
// only when a second fired item is found while the register is still occupied
module timer_slot_table #(
   parameter int SLOTS = tst_pkg::DEFAULT_SLOTS
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [1:0]  req_tuser,   // cmd
   input  wire logic [71:0] req_tdata,   // now[31:0], interval[63:32], slot[67:64], zero pad
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [1:0]       rsp_tuser,   // kind
   output logic [7:0]       rsp_tdata,   // slot_res[3:0], zero pad
   output logic             rsp_tlast    // last
);

   import tst_pkg::*;

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W = $clog2(SLOTS + 1);

   // input field split
   logic [31:0] req_now;
   logic [31:0] req_ivl;
   logic [3:0]  req_slot;
   logic [IDX_W-1:0] sel_idx;
   logic        sel_ok;

   assign req_now  = req_tdata[31:0];
   assign req_ivl  = req_tdata[63:32];
   assign req_slot = req_tdata[67:64];
   assign sel_idx  = IDX_W'(req_slot);
   assign sel_ok   = (32'(req_slot) < 32'(SLOTS));

   // control state
   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  eval_valid_ff, eval_valid_in;
   logic [IDX_W-1:0]      eval_idx_ff, eval_idx_in;
   logic                  hold_valid_ff, hold_valid_in;
   logic [IDX_W-1:0]      hold_idx_ff, hold_idx_in;
   logic [FIRE_CNT_W-1:0] fire_cnt_ff, fire_cnt_in;
   logic [SLOTS-1:0]      live_ff, live_in;
   logic [SLOTS-1:0]      one_shot_ff, one_shot_in;
   logic [SLOTS-1:0]      pend_ff, pend_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // payload registers
   logic                  attach_once_ff, attach_once_in;
   logic [31:0]           now_ff, now_in;
   logic [31:0]           ivl_ff, ivl_in;
   logic [1:0]            rsp_kind_ff, rsp_kind_in;
   logic [3:0]            rsp_slot_ff, rsp_slot_in;
   logic                  rsp_last_ff, rsp_last_in;

   // timing memories, registered read
   logic [31:0]      start_mem [SLOTS];
   logic [31:0]      period_mem [SLOTS];
   logic [31:0]      start_rd_ff;
   logic [31:0]      period_rd_ff;
   logic             start_we;
   logic             period_we;
   logic [IDX_W-1:0] wr_addr;
   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;

   logic             rsp_free;
   logic [IDX_W-1:0] att_idx;
   logic             due;
   logic             fire;
   logic             stall;

   assign rsp_free = !rsp_valid_ff || rsp_tready;
   assign att_idx  = cnt_ff[IDX_W-1:0];

   // wrapping age against period for the slot in the evaluate stage
   assign due  = ((now_ff - start_rd_ff) >= period_rd_ff);
   assign fire = eval_valid_ff && live_ff[eval_idx_ff] && !pend_ff[eval_idx_ff]
                 && (fire_cnt_ff < FIRE_CNT_W'(MAX_FIRED)) && due;
   // a new fired item must push the held one out first
   assign stall = fire && hold_valid_ff && !rsp_free;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = {4'b0000, rsp_slot_ff};
   assign rsp_tlast  = rsp_last_ff;

   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      eval_valid_in  = eval_valid_ff;
      eval_idx_in    = eval_idx_ff;
      hold_valid_in  = hold_valid_ff;
      hold_idx_in    = hold_idx_ff;
      fire_cnt_in    = fire_cnt_ff;
      live_in        = live_ff;
      one_shot_in    = one_shot_ff;
      pend_in        = pend_ff;
      attach_once_in = attach_once_ff;
      now_in         = now_ff;
      ivl_in         = ivl_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_kind_in    = rsp_kind_ff;
      rsp_slot_in    = rsp_slot_ff;
      rsp_last_in    = rsp_last_ff;
      start_we       = 1'b0;
      period_we      = 1'b0;
      wr_addr        = att_idx;
      rd_en          = 1'b0;
      rd_addr        = att_idx;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               now_in = req_now;
               ivl_in = req_ivl;
               cnt_in = '0;
               case (req_tuser)
                  CMD_ATTACH_ONCE, CMD_ATTACH_PER: begin
                     attach_once_in = (req_tuser == CMD_ATTACH_ONCE);
                     state_in       = S_ATTACH;
                  end
                  CMD_DETACH: begin
                     if (sel_ok && live_ff[sel_idx]) begin
                        pend_in[sel_idx] = 1'b1;
                     end
                  end
                  CMD_TICK: begin
                     eval_valid_in = 1'b0;
                     hold_valid_in = 1'b0;
                     fire_cnt_in   = '0;
                     state_in      = S_TICK;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end

         // walk the live flags up from slot 0
         S_ATTACH: begin
            if (rsp_free) begin
               if (!live_ff[att_idx]) begin
                  live_in[att_idx]     = 1'b1;
                  one_shot_in[att_idx] = attach_once_ff;
                  pend_in[att_idx]     = 1'b0;
                  start_we             = 1'b1;
                  period_we            = 1'b1;
                  rsp_valid_in         = 1'b1;
                  rsp_kind_in          = KIND_ATTACHED;
                  rsp_slot_in          = 4'(att_idx);
                  rsp_last_in          = 1'b1;
                  state_in             = S_IDLE;
               end else if (cnt_ff == CNT_W'(SLOTS - 1)) begin
                  rsp_valid_in = 1'b1;
                  rsp_kind_in  = KIND_FULL;
                  rsp_slot_in  = 4'b0000;
                  rsp_last_in  = 1'b1;
                  state_in     = S_IDLE;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end

         // read stage at cnt, evaluate stage one slot behind
         S_TICK: begin
            if (!stall) begin
               if (eval_valid_ff && live_ff[eval_idx_ff]) begin
                  if (pend_ff[eval_idx_ff]) begin
                     live_in[eval_idx_ff] = 1'b0;
                     pend_in[eval_idx_ff] = 1'b0;
                  end else if (fire) begin
                     if (hold_valid_ff) begin
                        rsp_valid_in = 1'b1;
                        rsp_kind_in  = KIND_FIRED;
                        rsp_slot_in  = 4'(hold_idx_ff);
                        rsp_last_in  = 1'b0;
                     end
                     hold_valid_in = 1'b1;
                     hold_idx_in   = eval_idx_ff;
                     fire_cnt_in   = fire_cnt_ff + 1'b1;
                     if (one_shot_ff[eval_idx_ff]) begin
                        live_in[eval_idx_ff] = 1'b0;
                     end else begin
                        start_we = 1'b1;
                        wr_addr  = eval_idx_ff;
                     end
                  end
               end
               if (cnt_ff < CNT_W'(SLOTS)) begin
                  rd_en         = 1'b1;
                  rd_addr       = cnt_ff[IDX_W-1:0];
                  eval_valid_in = 1'b1;
                  eval_idx_in   = cnt_ff[IDX_W-1:0];
                  cnt_in        = cnt_ff + 1'b1;
               end else begin
                  eval_valid_in = 1'b0;
                  if (!eval_valid_ff) begin
                     state_in = S_FLUSH;
                  end
               end
            end
         end

         // the held fired item goes out marked last
         S_FLUSH: begin
            if (!hold_valid_ff) begin
               state_in = S_IDLE;
            end else if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = KIND_FIRED;
               rsp_slot_in   = 4'(hold_idx_ff);
               rsp_last_in   = 1'b1;
               hold_valid_in = 1'b0;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cnt_ff        <= '0;
         eval_valid_ff <= 1'b0;
         hold_valid_ff <= 1'b0;
         fire_cnt_ff   <= '0;
         live_ff       <= '0;
         one_shot_ff   <= '0;
         pend_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         eval_valid_ff <= eval_valid_in;
         hold_valid_ff <= hold_valid_in;
         fire_cnt_ff   <= fire_cnt_in;
         live_ff       <= live_in;
         one_shot_ff   <= one_shot_in;
         pend_ff       <= pend_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      eval_idx_ff    <= eval_idx_in;
      hold_idx_ff    <= hold_idx_in;
      attach_once_ff <= attach_once_in;
      now_ff         <= now_in;
      ivl_ff         <= ivl_in;
      rsp_kind_ff    <= rsp_kind_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_last_ff    <= rsp_last_in;
   end

   // start time and period store
   always_ff @(posedge clock) begin
      if (start_we) begin
         start_mem[wr_addr] <= now_ff;
      end
      if (period_we) begin
         period_mem[wr_addr] <= ivl_ff;
      end
      if (rd_en) begin
         start_rd_ff  <= start_mem[rd_addr];
         period_rd_ff <= period_mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

[test/tb_timer_slot_table.sv]
`default_nettype none

module tb_timer_slot_table;
   import tst_pkg::*;

   localparam int SLOTS = DEFAULT_SLOTS;

   // one command item as it travels on the request channel
   typedef struct packed {
      logic [1:0]  cmd;
      logic [31:0] now;
      logic [31:0] ivl;
      logic [3:0]  sel;
   } timer_cmd_type;

   // one result item: kind, slot number and the last flag
   typedef struct packed {
      logic [1:0] kind;
      logic [3:0] slot;
      logic       last;
   } slot_event_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [1:0]  req_tuser  = '0;   // cmd
   logic [71:0] req_tdata  = '0;   // now[31:0], interval[63:32], slot[67:64], zero pad
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [1:0]  rsp_tuser;         // kind
   logic [7:0]  rsp_tdata;         // slot_res[3:0], zero pad
   logic        rsp_tlast;         // last

   timer_slot_table #(.SLOTS(SLOTS)) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #1 clock = ~clock;

   // commands waiting for the driver, and result items still owed by the block
   timer_cmd_type  cmd_q[$];
   slot_event_type slot_events_q[$];

   // shadow copy of the slot table
   logic [SLOTS-1:0] slot_live   = '0;
   logic [SLOTS-1:0] slot_once   = '0;
   logic [SLOTS-1:0] slot_kill   = '0;
   logic [31:0]      slot_start [SLOTS];
   logic [31:0]      slot_period[SLOTS];

   int  req_count = 0;   // accepted command items
   int  errors    = 0;
   int  hold_left = 0;
   bit  hold_done = 1'b0;

   // window of accepted commands in which neither side idles
   wire calm = (req_count >= 180) && (req_count < 250);

   // apply one accepted command to the shadow table and queue what it must produce
   function automatic void table_step(input timer_cmd_type c);
      slot_event_type fired[$];
      slot_event_type ev;
      int             i;
      case (c.cmd)
         CMD_ATTACH_ONCE, CMD_ATTACH_PER: begin
            // lowest slot that is not live; a slot marked for detach still counts as live
            ev = '{kind: KIND_FULL, slot: 4'd0, last: 1'b1};
            for (i = 0; i < SLOTS; i++) begin
               if (!slot_live[i]) begin
                  slot_live[i]   = 1'b1;
                  slot_once[i]   = (c.cmd == CMD_ATTACH_ONCE);
                  slot_kill[i]   = 1'b0;
                  slot_start[i]  = c.now;
                  slot_period[i] = c.ivl;
                  ev.kind        = KIND_ATTACHED;
                  ev.slot        = i[3:0];
                  break;
               end
            end
            slot_events_q.push_back(ev);
         end
         CMD_DETACH: begin
            // free slots are ignored, a repeated mark just stays set
            if (slot_live[c.sel]) slot_kill[c.sel] = 1'b1;
         end
         default: begin
            // tick: free marked slots, fire due ones in slot order
            for (i = 0; i < SLOTS; i++) begin
               if (!slot_live[i]) continue;
               if (slot_kill[i]) begin
                  slot_live[i] = 1'b0;
                  slot_kill[i] = 1'b0;
                  continue;
               end
               if (fired.size() >= MAX_FIRED) continue;
               // wrapping age compared against the interval
               if (c.now - slot_start[i] >= slot_period[i]) begin
                  fired.push_back('{kind: KIND_FIRED, slot: i[3:0], last: 1'b0});
                  if (slot_once[i]) slot_live[i] = 1'b0;
                  else slot_start[i] = c.now;
               end
            end
            if (fired.size() > 0) fired[fired.size()-1].last = 1'b1;
            foreach (fired[k]) slot_events_q.push_back(fired[k]);
         end
      endcase
   endfunction

   function automatic void push_cmd(input logic [1:0] cmd, input logic [31:0] now,
                                    input logic [31:0] ivl, input logic [3:0] sel);
      cmd_q.push_back('{cmd: cmd, now: now, ivl: ivl, sel: sel});
   endfunction

   // request driver: valid holds until the item is taken, gaps at random
   always @(posedge clock) begin
      timer_cmd_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (cmd_q.size() > 0 && (calm || $urandom_range(99) >= 29)) begin
            nxt = cmd_q.pop_front();
            req_tvalid <= 1'b1;
            req_tuser  <= nxt.cmd;
            req_tdata  <= {4'b0, nxt.sel, nxt.ivl, nxt.now};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // result receiver: random stalls, plus one long hold-off once traffic is going
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (!hold_done && req_count >= 60) begin
         rsp_tready <= 1'b0;
         hold_left  <= 300;
         hold_done  <= 1'b1;
      end else begin
         rsp_tready <= calm || ($urandom_range(99) >= 29);
      end
   end

   // monitor: predict on every accepted command first, then check any accepted result
   always @(posedge clock) begin
      slot_event_type exp_ev;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            table_step('{cmd: req_tuser, now: req_tdata[31:0], ivl: req_tdata[63:32],
                         sel: req_tdata[67:64]});
            req_count <= req_count + 1;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (slot_events_q.size() == 0) begin
               $error("result item with nothing expected: kind %0d slot_res %0d last %0b",
                      rsp_tuser, rsp_tdata[3:0], rsp_tlast);
               errors++;
            end else begin
               exp_ev = slot_events_q.pop_front();
               if (rsp_tuser !== exp_ev.kind) begin
                  $error("kind: expected %0d, actual %0d", exp_ev.kind, rsp_tuser);
                  errors++;
               end
               if (rsp_tdata[3:0] !== exp_ev.slot) begin
                  $error("slot_res: expected %0d, actual %0d", exp_ev.slot, rsp_tdata[3:0]);
                  errors++;
               end
               if (rsp_tlast !== exp_ev.last) begin
                  $error("last: expected %0b, actual %0b", exp_ev.last, rsp_tlast);
                  errors++;
               end
            end
         end
      end
   end

   // stimulus
   initial begin
      logic [31:0] clk_ms;
      logic [31:0] ivl;
      logic [3:0]  sel;
      int          r;
      int          n_live;
      int          i;

      // directed: empty tick, detach of a free slot, zero interval, wrapping age,
      // pending slot kept from reuse, repeated detach
      push_cmd(CMD_TICK,        32'h0000_0000, 32'h0000_0000, 4'h0);
      push_cmd(CMD_DETACH,      32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF);
      push_cmd(CMD_ATTACH_ONCE, 32'h0000_0000, 32'h0000_0000, 4'hF);
      push_cmd(CMD_ATTACH_PER,  32'hFFFF_FFF0, 32'h0000_0020, 4'h0);
      push_cmd(CMD_ATTACH_PER,  32'h0000_0000, 32'hFFFF_FFFF, 4'h5);
      push_cmd(CMD_DETACH,      32'h0000_0000, 32'h0000_0000, 4'h2);
      push_cmd(CMD_DETACH,      32'h0000_0000, 32'h0000_0000, 4'h2);
      push_cmd(CMD_ATTACH_ONCE, 32'h0000_0005, 32'h0000_0003, 4'hA);
      push_cmd(CMD_TICK,        32'h0000_0010, 32'h0000_0000, 4'h0);
      // fill the table, one more attach sees it full, then every slot fires at once
      for (i = 0; i < SLOTS; i++)
         push_cmd(CMD_ATTACH_PER, 32'h0000_0020 + i, 32'h0000_0000, i[3:0]);
      push_cmd(CMD_TICK,        32'h0000_0040, 32'h0000_0000, 4'h0);

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // random: a running millisecond clock starting anywhere, so it wraps now and then
      clk_ms = $urandom;
      for (i = 0; i < 300; i++) begin
         while (cmd_q.size() >= 2) @(negedge clock);
         // sender pause: let the block drain completely
         if (i == 150) begin
            while (cmd_q.size() > 0 || req_tvalid || slot_events_q.size() > 0)
               @(negedge clock);
         end
         n_live = $countones(slot_live);
         r = $urandom_range(99);
         // a crowded table gets more detaches so it drains and fills again
         if ((n_live >= 12) ? (r < 20) : (r < 40)) begin
            r = $urandom_range(99);
            if (r < 5) ivl = 32'h0;
            else if (r < 10) ivl = $urandom;
            else if (r < 13) ivl = 32'hFFFF_FFFF;
            else ivl = $urandom_range(40);
            clk_ms += $urandom_range(3);
            push_cmd($urandom_range(1) ? CMD_ATTACH_PER : CMD_ATTACH_ONCE, clk_ms, ivl,
                     4'($urandom));
         end else if ((n_live >= 12) ? (r < 65) : (r < 60)) begin
            sel = 4'($urandom);
            // mostly a live slot, sometimes whatever comes
            if (n_live > 0 && $urandom_range(99) < 85)
               while (!slot_live[sel]) sel = 4'($urandom);
            push_cmd(CMD_DETACH, $urandom, $urandom, sel);
         end else begin
            if ($urandom_range(99) < 3) clk_ms += $urandom;
            else clk_ms += $urandom_range(25);
            push_cmd(CMD_TICK, clk_ms, $urandom, 4'($urandom));
         end
      end

      // everything accepted, everything delivered, then a quiet tail for stray items
      while (cmd_q.size() > 0 || req_tvalid) @(negedge clock);
      while (slot_events_q.size() > 0) @(negedge clock);
      repeat (40) @(negedge clock);
      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // watchdog
   initial begin
      #1000000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

`default_nettype wire

[files.f]
hdl/tst_pkg.sv
hdl/timer_slot_table.sv
test/tb_timer_slot_table.sv
